FILE: design/time_string_to_sample_position_core_defines.svh
// Assertion macros for the file that carries the concurrent checks.
`ifndef TIME_STRING_TO_SAMPLE_POSITION_CORE_DEFINES_SVH
`define TIME_STRING_TO_SAMPLE_POSITION_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/tsp_pkg.sv
package tsp_pkg;

   localparam int RATE_W = 20;
   localparam logic [RATE_W-1:0] RATE_RESET = 20'd44100;

   // Characters the parser reacts to.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // floor(t / 10) == (t * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit t.
   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam int DIV10_SHIFT = 35;

   typedef enum logic [1:0] {
      PH_BEFORE = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } req_type;

   typedef struct packed {
      logic signed [63:0] position;
      logic               error;
   } rsp_type;

   typedef struct packed {
      logic char_en;
      logic finish;
      logic mul_lo;
      logic mul_hi;
      logic acc;
      logic f_mul;
      logic f_div;
      logic f_quo;
      logic add;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic colon_seen;
      logic fin_error;
      logic frac_pending;
      logic frac_last;
   } sts_type;

endpackage

FILE: design/tsp_ctrl.sv
module tsp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   input  logic             rsp_ready,
   input  tsp_pkg::sts_type sts,
   output logic             req_ready,
   output logic             rsp_valid,
   output tsp_pkg::cmd_type cmd
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_FINISH = 10'b00_0000_0010,
      ST_MUL_LO = 10'b00_0000_0100,
      ST_MUL_HI = 10'b00_0000_1000,
      ST_ACC    = 10'b00_0001_0000,
      ST_F_MUL  = 10'b00_0010_0000,
      ST_F_DIV  = 10'b00_0100_0000,
      ST_F_QUO  = 10'b00_1000_0000,
      ST_ADD    = 10'b01_0000_0000,
      ST_DONE   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.char_en = 1'b1;
               if (req_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            if (!sts.colon_seen || sts.fin_error) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = sts.frac_pending ? ST_F_MUL : ST_DONE;
         end
         ST_F_MUL: begin
            cmd.f_mul = 1'b1;
            state_in  = ST_F_DIV;
         end
         ST_F_DIV: begin
            cmd.f_div = 1'b1;
            state_in  = ST_F_QUO;
         end
         ST_F_QUO: begin
            cmd.f_quo = 1'b1;
            state_in  = sts.frac_last ? ST_ADD : ST_F_MUL;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/tsp_dpath.sv
module tsp_dpath #(
   parameter int FRAC_DIGITS = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tsp_pkg::cmd_type              cmd,
   input  tsp_pkg::req_type              req_data,
   input  logic                          csr_write_enable,
   input  logic [tsp_pkg::RATE_W-1:0]    csr_write_data,
   output tsp_pkg::sts_type              sts,
   output tsp_pkg::rsp_type              rsp_data
);

   localparam int CNT_W = $clog2(FRAC_DIGITS + 1);

   typedef struct packed {
      tsp_pkg::phase_type phase;
      logic [63:0]        val;
      logic               neg;
   } parse_type;

   localparam parse_type PARSE_CLEAR = '{phase: tsp_pkg::PH_BEFORE, val: 64'd0, neg: 1'b0};

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= tsp_pkg::CHAR_ZERO) && (c <= tsp_pkg::CHAR_NINE);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == tsp_pkg::CHAR_SPACE) || ((c >= tsp_pkg::CHAR_TAB) && (c <= tsp_pkg::CHAR_CR));
   endfunction

   function automatic logic [63:0] mul10(input logic [63:0] x);
      return (x << 3) + (x << 1);
   endfunction

   function automatic logic [63:0] mul60(input logic [63:0] x);
      return (x << 6) - (x << 2);
   endfunction

   // One character into a sign and digit parser.
   function automatic parse_type parse_step(input logic [7:0] c, input parse_type cur);
      parse_type nxt;
      logic      dig;
      nxt = cur;
      dig = is_digit(c);
      unique case (cur.phase)
         tsp_pkg::PH_BEFORE: begin
            if (!is_blank(c)) begin
               if ((c == tsp_pkg::CHAR_PLUS) || (c == tsp_pkg::CHAR_MINUS)) begin
                  nxt.neg   = (c == tsp_pkg::CHAR_MINUS);
                  nxt.phase = tsp_pkg::PH_SIGN;
               end else if (dig) begin
                  nxt.val   = 64'(c[3:0]);
                  nxt.phase = tsp_pkg::PH_DIGITS;
               end else begin
                  nxt.phase = tsp_pkg::PH_DONE;
               end
            end
         end
         tsp_pkg::PH_SIGN: begin
            if (dig) begin
               nxt.val   = 64'(c[3:0]);
               nxt.phase = tsp_pkg::PH_DIGITS;
            end else begin
               nxt.phase = tsp_pkg::PH_DONE;
            end
         end
         tsp_pkg::PH_DIGITS: begin
            if (dig) begin
               nxt.val = mul10(cur.val) + 64'(c[3:0]);
            end else begin
               nxt.phase = tsp_pkg::PH_DONE;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
      return nxt;
   endfunction

   logic [tsp_pkg::RATE_W-1:0] rate_ff;
   parse_type                  raw_ff, raw_in;
   parse_type                  fld_ff, fld_in;
   logic [63:0]                total_ff, total_in;
   logic                       colon_ff, colon_in;
   logic                       dot_ff, dot_in;
   logic                       terr_ff, terr_in;
   logic                       ended_ff, ended_in;
   logic [CNT_W-1:0]           fcnt_ff, fcnt_in;
   logic [3:0]                 fdig_ff [FRAC_DIGITS];
   logic [3:0]                 fdig_in [FRAC_DIGITS];
   logic [63:0]                prod_ff, prod_in;
   logic [63:0]                acc_ff, acc_in;
   logic [tsp_pkg::RATE_W-1:0] r_ff, r_in;
   tsp_pkg::rsp_type           rsp_ff, rsp_in;
   logic [31:0]                mul_a, mul_b;
   logic                       close_err;
   logic [63:0]                close_total;
   logic [7:0]                 c;

   assign c           = req_data.character;
   assign close_err   = fld_ff.neg && (fld_ff.val != 64'd0);
   assign close_total = mul60(total_ff) + fld_ff.val;

   // Parser state.
   always_comb begin
      raw_in   = raw_ff;
      fld_in   = fld_ff;
      total_in = total_ff;
      colon_in = colon_ff;
      dot_in   = dot_ff;
      terr_in  = terr_ff;
      ended_in = ended_ff;
      fcnt_in  = fcnt_ff;
      fdig_in  = fdig_ff;
      if (cmd.char_en) begin
         if (!ended_ff) begin
            if (c == tsp_pkg::CHAR_NUL) begin
               ended_in = 1'b1;
            end else begin
               raw_in = parse_step(c, raw_ff);
               if (c == tsp_pkg::CHAR_COLON) begin
                  colon_in = 1'b1;
               end
               if (terr_ff) begin
                  terr_in = 1'b1;
               end else if (dot_ff) begin
                  if (fld_ff.phase == tsp_pkg::PH_DIGITS) begin
                     if (!is_digit(c)) begin
                        fld_in.phase = tsp_pkg::PH_DONE;
                     end else if (fcnt_ff < CNT_W'(FRAC_DIGITS)) begin
                        for (int i = FRAC_DIGITS - 1; i > 0; i--) begin
                           fdig_in[i] = fdig_ff[i-1];
                        end
                        fdig_in[0] = c[3:0];
                        fcnt_in    = fcnt_ff + CNT_W'(1);
                     end
                  end
               end else if ((c == tsp_pkg::CHAR_COLON) || (c == tsp_pkg::CHAR_DOT)) begin
                  fld_in = PARSE_CLEAR;
                  if (close_err) begin
                     terr_in = 1'b1;
                  end else begin
                     total_in = close_total;
                     if (c == tsp_pkg::CHAR_DOT) begin
                        dot_in       = 1'b1;
                        fld_in.phase = tsp_pkg::PH_DIGITS;
                     end
                  end
               end else begin
                  fld_in = parse_step(c, fld_ff);
               end
            end
         end
      end else if (cmd.finish) begin
         if (colon_ff && !terr_ff && !dot_ff) begin
            fld_in = PARSE_CLEAR;
            if (close_err) begin
               terr_in = 1'b1;
            end else begin
               total_in = close_total;
            end
         end
      end else if (cmd.f_quo) begin
         // The newest digit is consumed first; the rest move down one place.
         for (int i = 0; i < FRAC_DIGITS - 1; i++) begin
            fdig_in[i] = fdig_ff[i+1];
         end
         fdig_in[FRAC_DIGITS-1] = 4'd0;
         fcnt_in = fcnt_ff - CNT_W'(1);
      end else if (cmd.load_out) begin
         raw_in   = PARSE_CLEAR;
         fld_in   = PARSE_CLEAR;
         total_in = 64'd0;
         colon_in = 1'b0;
         dot_in   = 1'b0;
         terr_in  = 1'b0;
         ended_in = 1'b0;
         fcnt_in  = '0;
      end
   end

   // Shared multiplier: 64-bit total times rate in two halves, then per
   // fraction digit a digit times rate and a divide by ten via reciprocal.
   always_comb begin
      mul_a = total_ff[31:0];
      mul_b = 32'(rate_ff);
      if (cmd.mul_hi) begin
         mul_a = total_ff[63:32];
      end else if (cmd.f_mul) begin
         mul_a = 32'(fdig_ff[0]);
      end else if (cmd.f_div) begin
         mul_a = prod_ff[31:0] + 32'(r_ff);
         mul_b = tsp_pkg::DIV10_RECIP;
      end
   end

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      acc_in = acc_ff;
      r_in   = r_ff;
      if (cmd.mul_hi) begin
         acc_in = prod_ff;
      end else if (cmd.acc) begin
         acc_in = acc_ff + {prod_ff[31:0], 32'd0};
         r_in   = '0;
      end else if (cmd.f_quo) begin
         r_in = prod_ff[tsp_pkg::DIV10_SHIFT +: tsp_pkg::RATE_W];
      end else if (cmd.add) begin
         acc_in = acc_ff + 64'(r_ff);
      end
   end

   always_comb begin
      rsp_in.error = colon_ff && terr_ff;
      if (!colon_ff) begin
         rsp_in.position = raw_ff.neg ? (64'd0 - raw_ff.val) : raw_ff.val;
      end else if (terr_ff) begin
         rsp_in.position = '1;
      end else begin
         rsp_in.position = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= tsp_pkg::RATE_RESET;
         raw_ff   <= PARSE_CLEAR;
         fld_ff   <= PARSE_CLEAR;
         total_ff <= 64'd0;
         colon_ff <= 1'b0;
         dot_ff   <= 1'b0;
         terr_ff  <= 1'b0;
         ended_ff <= 1'b0;
         fcnt_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            rate_ff <= csr_write_data;
         end
         raw_ff   <= raw_in;
         fld_ff   <= fld_in;
         total_ff <= total_in;
         colon_ff <= colon_in;
         dot_ff   <= dot_in;
         terr_ff  <= terr_in;
         ended_ff <= ended_in;
         fcnt_ff  <= fcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      fdig_ff <= fdig_in;
      acc_ff  <= acc_in;
      r_ff    <= r_in;
      if (cmd.mul_lo || cmd.mul_hi || cmd.f_mul || cmd.f_div) begin
         prod_ff <= prod_in;
      end
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign sts.colon_seen   = colon_ff;
   assign sts.fin_error    = terr_ff || (colon_ff && !dot_ff && close_err);
   assign sts.frac_pending = dot_ff && (fcnt_ff != '0);
   assign sts.frac_last    = (fcnt_ff == CNT_W'(1));
   assign rsp_data         = rsp_ff;

endmodule

FILE: design/time_string_to_sample_position_core.sv
// A last beat gives its result after the states FINISH and DONE without ':' or with a
// bad field, after FINISH, MUL_LO, MUL_HI, ACC and DONE with ':' and no fraction digits,
// and with fraction digits F_MUL, F_DIV and F_QUO per digit and then ADD come before DONE.
// Throughput: one character beat per cycle; after a last beat the input stalls for the
// scaling, set by one shared 32x32 multiplier (two halves, then three steps per digit).
// Reset is synchronous, active high: the parser clears and sample_rate returns to 44100.
`include "time_string_to_sample_position_core_defines.svh"

module time_string_to_sample_position_core #(
   parameter int FRAC_DIGITS = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tsp_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output tsp_pkg::rsp_type           rsp_data,
   input  logic                       csr_write_enable,
   input  logic [tsp_pkg::RATE_W-1:0] csr_write_data
);

   // The controller steps through the final scaling and owns the result
   // valid flag; the datapath holds the parser, the multiplier and the
   // result register. They talk only through the command and status structs.
   tsp_pkg::cmd_type cmd;
   tsp_pkg::sts_type sts;

   tsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Each accepted character beat updates the parser in the same cycle. The
   // beat marked last starts the scaling: the field is closed, the total in
   // seconds is multiplied by the rate, and the fraction digits are folded
   // in from the last one upward, each as digit times rate plus a carry,
   // divided by ten.
   tsp_dpath #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .sts              (sts),
      .rsp_data         (rsp_data)
   );

   // After the last beat of a string the input must stall for the scaling.
   `TSP_ASSERT_NEXT(a_stall_after_last, clock, reset,
      req_valid && req_ready && req_data.last, !req_ready, "input taken during scaling")

   // An error result always carries position -1.
   `TSP_ASSERT_IMP(a_error_position, clock, reset,
      rsp_valid && rsp_data.error, &rsp_data.position, "error result without -1")

   // The result register is never reloaded over a beat not yet taken.
   `TSP_ASSERT_IMP(a_no_overwrite, clock, reset,
      cmd.load_out, !rsp_valid || rsp_ready, "pending result overwritten")

endmodule

FILE: tb/time_string_to_sample_position_core_test.sv
class position_checker #(int FRAC_LIMIT = 9);
   logic [tsp_pkg::RATE_W-1:0] rate = tsp_pkg::RATE_RESET;

   // Parser state for the leading integer.
   logic [63:0]        lead_value;
   tsp_pkg::phase_type lead_phase;
   bit                 lead_minus;
   // Parser state for the colon fields and the fraction.
   bit                 colon_found;
   logic [63:0]        field_value;
   tsp_pkg::phase_type field_phase;
   bit                 field_minus;
   logic [63:0]        seconds;
   bit                 dot_found;
   logic [63:0]        frac_value;
   int                 frac_count;
   bit                 bad_field;
   bit                 nul_found;

   tsp_pkg::rsp_type due_positions[$];
   int mismatches;
   int checked;
   int error_results;
   int strings;

   function void clear_string();
      lead_value  = '0;
      lead_phase  = tsp_pkg::PH_BEFORE;
      lead_minus  = 1'b0;
      colon_found = 1'b0;
      field_value = '0;
      field_phase = tsp_pkg::PH_BEFORE;
      field_minus = 1'b0;
      seconds     = '0;
      dot_found   = 1'b0;
      frac_value  = '0;
      frac_count  = 0;
      bad_field   = 1'b0;
      nul_found   = 1'b0;
   endfunction

   function bit is_digit(input logic [7:0] c);
      return c >= tsp_pkg::CHAR_ZERO && c <= tsp_pkg::CHAR_NINE;
   endfunction

   function bit is_blank(input logic [7:0] c);
      return c == tsp_pkg::CHAR_SPACE || (c >= tsp_pkg::CHAR_TAB && c <= tsp_pkg::CHAR_CR);
   endfunction

   // Blanks, an optional sign, then decimal digits that wrap at 64 bits.
   function void number_step(input logic [7:0] c, inout tsp_pkg::phase_type ph,
                             inout logic [63:0] val, inout bit minus);
      unique case (ph)
         tsp_pkg::PH_BEFORE: begin
            if (!is_blank(c)) begin
               if (c == tsp_pkg::CHAR_PLUS || c == tsp_pkg::CHAR_MINUS) begin
                  minus = (c == tsp_pkg::CHAR_MINUS);
                  ph = tsp_pkg::PH_SIGN;
               end else if (is_digit(c)) begin
                  val = c - tsp_pkg::CHAR_ZERO;
                  ph = tsp_pkg::PH_DIGITS;
               end else begin
                  ph = tsp_pkg::PH_DONE;
               end
            end
         end
         tsp_pkg::PH_SIGN: begin
            if (is_digit(c)) begin
               val = c - tsp_pkg::CHAR_ZERO;
               ph = tsp_pkg::PH_DIGITS;
            end else begin
               ph = tsp_pkg::PH_DONE;
            end
         end
         tsp_pkg::PH_DIGITS: begin
            if (is_digit(c)) begin
               val = val * 10 + (c - tsp_pkg::CHAR_ZERO);
            end else begin
               ph = tsp_pkg::PH_DONE;
            end
         end
         default: begin
         end
      endcase
   endfunction

   function void close_field();
      if (field_minus && field_value != 0) begin
         bad_field = 1'b1;
      end else begin
         seconds = seconds * 60 + field_value;
      end
      field_value = '0;
      field_phase = tsp_pkg::PH_BEFORE;
      field_minus = 1'b0;
   endfunction

   function void take_character(input logic [7:0] c, input bit final_char);
      logic [127:0]     product;
      logic [127:0]     scale;
      tsp_pkg::rsp_type due;
      if (!nul_found) begin
         if (c == tsp_pkg::CHAR_NUL) begin
            nul_found = 1'b1;
         end else begin
            number_step(c, lead_phase, lead_value, lead_minus);
            if (c == tsp_pkg::CHAR_COLON) begin
               colon_found = 1'b1;
            end
            if (!bad_field) begin
               if (dot_found) begin
                  if (field_phase == tsp_pkg::PH_DIGITS) begin
                     if (!is_digit(c)) begin
                        field_phase = tsp_pkg::PH_DONE;
                     end else if (frac_count < FRAC_LIMIT) begin
                        frac_value = frac_value * 10 + (c - tsp_pkg::CHAR_ZERO);
                        frac_count++;
                     end
                  end
               end else if (c == tsp_pkg::CHAR_COLON) begin
                  close_field();
               end else if (c == tsp_pkg::CHAR_DOT) begin
                  close_field();
                  if (!bad_field) begin
                     dot_found = 1'b1;
                     field_phase = tsp_pkg::PH_DIGITS;
                  end
               end else begin
                  number_step(c, field_phase, field_value, field_minus);
               end
            end
         end
      end
      if (final_char) begin
         due.error = 1'b0;
         if (!colon_found) begin
            due.position = lead_minus ? 64'd0 - lead_value : lead_value;
         end else begin
            if (!bad_field && !dot_found) begin
               close_field();
            end
            if (bad_field) begin
               due.position = '1;
               due.error = 1'b1;
               error_results++;
            end else begin
               due.position = seconds * rate;
               if (dot_found) begin
                  product = frac_value * rate;
                  scale = 1;
                  repeat (frac_count) scale = scale * 10;
                  due.position = due.position + 64'(product / scale);
               end
            end
         end
         due_positions.push_back(due);
         clear_string();
      end
   endfunction

   task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      if (mismatches < 25) begin
         $display("MISMATCH %s: got %h, expected %h", what, got, want);
      end
      mismatches++;
   endtask

   task check_position(input tsp_pkg::rsp_type got);
      tsp_pkg::rsp_type want;
      if (due_positions.size() == 0) begin
         report_mismatch("position with nothing due", got.position, '0);
         return;
      end
      want = due_positions.pop_front();
      checked++;
      if (got.position !== want.position) begin
         report_mismatch("position", got.position, want.position);
      end
      if (got.error !== want.error) begin
         report_mismatch("error flag", 64'(got.error), 64'(want.error));
      end
   endtask
endclass

module time_string_to_sample_position_core_test;
   localparam int FRAC_DIGITS = 9;
   localparam int RATE_BITS = tsp_pkg::RATE_W;
   // Settling time, longer than the slowest scaling with FRAC_DIGITS fraction digits.
   localparam int SETTLE_CYCLES = 40;
   // Length of the one long stall of the result side.
   localparam int CHOKE_CYCLES = 300;
   // Cycles without any handshake or register write before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 2000;
   // Characters per random phase; seven phases plus the directed strings give about 1100.
   localparam int PHASE_CHARS = 155;

   typedef enum int {
      SINK_FREE,
      SINK_COIN,
      SINK_SPARSE,
      SINK_RHYTHM
   } sink_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   tsp_pkg::req_type     req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   tsp_pkg::rsp_type     rsp_data;
   logic                 csr_write_enable = 1'b0;
   logic [RATE_BITS-1:0] csr_write_data = '0;

   position_checker #(FRAC_DIGITS) book;

   // The string being built and then sent, one character per beat.
   logic [7:0] text[$];
   int chars_sent = 0;
   int burst_left = 0;
   int settings = 0;
   int quiet_cycles = 0;
   bit choke_request = 1'b0;
   bit choke_done = 1'b0;

   // Short strings that hit the special cases by hand: a blank and a minus before a
   // number, a bare sign, a negative field, a "-0" field with a dot and no digits, and
   // a fraction that runs past the digit limit.
   string directed_texts[5] = '{"\t-12", "+", "1:-2", "-0:1.", ":.1234567891"};

   time_string_to_sample_position_core #(
      .FRAC_DIGITS(FRAC_DIGITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Any accepted beat or register write counts as progress. A long stretch without
   // one means the block has hung, so the run ends as a failure.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Offers one character and waits for the block to take it. Valid is left high so
   // that the next character can follow in the very next cycle.
   task automatic send_char(input logic [7:0] c, input bit final_char);
      req_valid <= 1'b1;
      req_data <= '{character: c, last: final_char};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.take_character(c, final_char);
      chars_sent++;
   endtask

   task automatic pause_input(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Sends the built string in bursts. Most gaps are short, some are long, and some
   // bursts run on for many beats so that back-to-back traffic is covered too.
   task automatic send_text();
      int j;
      book.strings++;
      for (j = 0; j < text.size(); j++) begin
         if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
               pause_input(($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
                                                       : $urandom_range(1, 4));
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 12);
         end
         burst_left--;
         send_char(text[j], j == text.size() - 1);
      end
   endtask

   // Stops offering input until every expected position has come back, then lets the
   // block settle for the longest latency it has.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (book.due_positions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rate(input logic [RATE_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      book.rate = value;
      settings++;
   endtask

   task automatic put_digits(input int count);
      repeat (count) text.push_back(8'(tsp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
   endtask

   task automatic put_blanks(input int count);
      int b;
      repeat (count) begin
         b = $urandom_range(tsp_pkg::CHAR_TAB, tsp_pkg::CHAR_CR + 1);
         text.push_back((b > tsp_pkg::CHAR_CR) ? tsp_pkg::CHAR_SPACE : 8'(b));
      end
   endtask

   // Field lengths: mostly one to three digits, now and then none, and now and then
   // long enough that the decimal value and the base-60 sum wrap around 64 bits.
   function automatic int number_length();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(12, 24);
      end
      return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
   endfunction

   // Builds and sends random strings until the budget of characters is used. Most of
   // them are well-formed time strings with random content; the rest are plain
   // integers, pure noise over all byte values, and time strings with one character
   // overwritten by a NUL or a random byte.
   task automatic run_random_phase(input int budget);
      int start;
      int kind;
      int fields;
      int f;
      int r;
      start = chars_sent;
      while (chars_sent - start < budget) begin
         text.delete();
         kind = $urandom_range(0, 99);
         if (kind < 12) begin
            repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 32) begin
            put_blanks($urandom_range(0, 2));
            r = $urandom_range(0, 3);
            if (r == 0) begin
               text.push_back(tsp_pkg::CHAR_MINUS);
            end else if (r == 1) begin
               text.push_back(tsp_pkg::CHAR_PLUS);
            end
            put_digits(number_length());
            if ($urandom_range(0, 3) == 0) begin
               text.push_back(8'($urandom_range(0, 255)));
            end
         end else begin
            fields = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 4);
            for (f = 0; f < fields; f++) begin
               if (f != 0) begin
                  text.push_back(tsp_pkg::CHAR_COLON);
               end
               if ($urandom_range(0, 9) == 0) begin
                  put_blanks(1);
               end
               // A minus on a nonzero field poisons the whole string.
               r = $urandom_range(0, 19);
               if (r == 0) begin
                  text.push_back(tsp_pkg::CHAR_MINUS);
               end else if (r == 1) begin
                  text.push_back(tsp_pkg::CHAR_PLUS);
               end
               put_digits(number_length());
            end
            if ($urandom_range(0, 2) != 0) begin
               // Up to twelve fraction digits, so the digit limit is often passed,
               // and sometimes a stray character followed by more digits.
               text.push_back(tsp_pkg::CHAR_DOT);
               put_digits($urandom_range(0, 12));
               if ($urandom_range(0, 4) == 0) begin
                  text.push_back(8'($urandom_range(tsp_pkg::CHAR_SPACE, 8'h7E)));
                  put_digits(2);
               end
            end
            if (kind >= 90 && text.size() != 0) begin
               text[$urandom_range(0, text.size() - 1)] =
                  $urandom_range(0, 1) ? tsp_pkg::CHAR_NUL : 8'($urandom_range(0, 255));
            end
         end
         if (text.size() == 0) begin
            text.push_back(tsp_pkg::CHAR_ZERO);
         end
         send_text();
      end
   endtask

   // The result side takes beats in changing moods: always ready, a coin toss, rarely
   // ready, or a fixed rhythm. Once, on request from the input side, it holds off for a
   // long stretch while characters keep coming, so that the block backs up.
   initial begin : result_sink
      int hold;
      int mode_left;
      sink_mode_type mode;
      hold = 0;
      mode_left = 0;
      mode = SINK_FREE;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            book.check_position(rsp_data);
         end
         if (choke_request && !choke_done) begin
            choke_done = 1'b1;
            hold = CHOKE_CYCLES;
         end
         if (mode_left == 0) begin
            mode = sink_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            unique case (mode)
               SINK_FREE:   rsp_ready <= 1'b1;
               SINK_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
               SINK_SPARSE: rsp_ready <= ($urandom_range(0, 4) == 0);
               default:     rsp_ready <= (mode_left % 3 != 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      int j;
      logic [RATE_BITS-1:0] rates[6];
      book = new;
      book.clear_string();
      // The sample rate runs through its extremes: the smallest legal rate, the
      // largest legal rate, the full register width, and zero, which must give zero.
      rates = '{20'd1, 20'd768000, 20'hFFFFF, 20'd0, 20'd48000, 20'd0};
      rates[5] = RATE_BITS'($urandom_range(2, 767999));
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed strings run at the rate that reset leaves in place.
      foreach (directed_texts[k]) begin
         text.delete();
         for (j = 0; j < directed_texts[k].len(); j++) begin
            text.push_back(directed_texts[k][j]);
         end
         send_text();
      end
      // A NUL ends the string early; the byte of all ones after it must be ignored.
      text.delete();
      text.push_back(tsp_pkg::CHAR_ZERO + 8'd1);
      text.push_back(tsp_pkg::CHAR_COLON);
      text.push_back(tsp_pkg::CHAR_NUL);
      text.push_back(8'hFF);
      send_text();

      run_random_phase(PHASE_CHARS);
      foreach (rates[k]) begin
         // The register is only written once the block has nothing in flight.
         drain_results();
         write_rate(rates[k]);
         if (k == 2) begin
            choke_request = 1'b1;
         end
         run_random_phase(PHASE_CHARS);
      end
      drain_results();

      $display("Sent %0d characters in %0d strings under %0d written sample rates.",
               chars_sent, book.strings, settings);
      $display("Checked %0d positions, %0d of them flagged as bad time fields.",
               book.checked, book.error_results);
      if (book.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
